@@ sv/fadd_pkg.sv @@
// Shared types and constants for the fraction add and reduce block.
// Used by the controller, the datapath, the divider and the top level.
package fadd_pkg;

    // Width of the divider operands: magnitudes fit in 31 bits
    localparam int C_DIV_W = 31;

    // Product select codes for the shared multiplier
    localparam logic [1:0] MUL_N1D2 = 2'd0;
    localparam logic [1:0] MUL_N2D1 = 2'd1;
    localparam logic [1:0] MUL_D1D2 = 2'd2;

    // Divider operation codes
    localparam logic [1:0] DIV_MOD = 2'd0;  // Euclid remainder step
    localparam logic [1:0] DIV_NUM = 2'd1;  // reduce numerator by gcd
    localparam logic [1:0] DIV_DEN = 2'd2;  // reduce denominator by gcd

    typedef struct packed {
        logic signed [15:0] first_numerator;
        logic        [14:0] first_denominator;
        logic signed [15:0] second_numerator;
        logic        [14:0] second_denominator;
    } t_in;

    typedef struct packed {
        logic signed [31:0] sum_numerator;
        logic        [29:0] sum_denominator;
        logic               status;
    } t_out;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load;       // capture input transaction
        logic       mul_en;     // register one product
        logic [1:0] mul_sel;
        logic       acc_ld;     // numerator <= product
        logic       acc_add;    // numerator += product
        logic       sum_ld;     // load magnitude and denominator
        logic       div_start;
        logic [1:0] div_op;
        logic       out_ld;     // load output register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic err;       // zero input denominator
        logic num_zero;  // summed numerator is zero
        logic b_zero;    // Euclid remainder reached zero
        logic div_done;
        logic out_free;  // output register can take a result
    } t_dp_sts;

endpackage

@@ sv/fadd_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on fadd_pkg for the operand width.
module fadd_div
    import fadd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [C_DIV_W-1:0] i_dividend,
    input  logic [C_DIV_W-1:0] i_divisor,
    output logic               o_done,
    output logic [C_DIV_W-1:0] o_quotient,
    output logic [C_DIV_W-1:0] o_remainder
);

    localparam int CW = $clog2(C_DIV_W);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [C_DIV_W-1:0] r_quo;
    logic [C_DIV_W-1:0] r_rem;
    logic [C_DIV_W-1:0] r_dvs;

    logic [C_DIV_W:0]   rem_sh;
    logic [C_DIV_W:0]   diff;
    logic               ge;

    // Shift in next dividend bit and trial subtract
    always_comb begin
        rem_sh = {r_rem, r_quo[C_DIV_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        ge     = !diff[C_DIV_W];
    end

    // Control: busy and done flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: iterate one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_cnt <= CW'(C_DIV_W - 1);
        end else if (r_busy) begin
            r_rem <= ge ? diff[C_DIV_W-1:0] : rem_sh[C_DIV_W-1:0];
            r_quo <= {r_quo[C_DIV_W-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

@@ sv/fadd_dp.sv @@
// Datapath: shared multiplier, numerator accumulator, Euclid registers and output register.
// Depends on fadd_pkg and instantiates fadd_div.
module fadd_dp
    import fadd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_in     i_in_data,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_out    o_out_data
);

    t_in                r_in;
    logic               r_err;
    logic signed [31:0] r_prod;
    logic signed [31:0] r_num;
    logic               r_neg;
    logic [C_DIV_W-1:0] r_mag;
    logic [C_DIV_W-1:0] r_den;
    logic [C_DIV_W-1:0] r_a;
    logic [C_DIV_W-1:0] r_b;
    logic [C_DIV_W-1:0] r_qnum;
    logic [C_DIV_W-1:0] r_qden;
    logic [1:0]         r_op;
    logic               r_out_valid;
    t_out               r_out;

    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] prod;
    logic signed [31:0] num_abs;
    logic [C_DIV_W-1:0] dvd;
    logic [C_DIV_W-1:0] dvs;
    logic               div_done;
    logic [C_DIV_W-1:0] div_quo;
    logic [C_DIV_W-1:0] div_rem;
    t_out               n_out;

    // Select multiplier operands: numerators sign-extend, denominators zero-extend
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_N1D2: begin
                mul_a = 17'(r_in.first_numerator);
                mul_b = $signed({2'b00, r_in.second_denominator});
            end
            MUL_N2D1: begin
                mul_a = 17'(r_in.second_numerator);
                mul_b = $signed({2'b00, r_in.first_denominator});
            end
            MUL_D1D2: begin
                mul_a = $signed({2'b00, r_in.first_denominator});
                mul_b = $signed({2'b00, r_in.second_denominator});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod    = mul_a * mul_b;
        num_abs = r_num[31] ? -r_num : r_num;
    end

    // Select divider operands
    always_comb begin
        case (i_cmd.div_op)
            DIV_MOD: begin
                dvd = r_a;
                dvs = r_b;
            end
            DIV_NUM: begin
                dvd = r_mag;
                dvs = r_a;
            end
            DIV_DEN: begin
                dvd = r_den;
                dvs = r_a;
            end
            default: begin
                dvd = r_a;
                dvs = r_b;
            end
        endcase
    end

    fadd_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (dvd),
        .i_divisor   (dvs),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Capture, multiply, accumulate and Euclid register updates
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in  <= i_in_data;
            r_err <= (i_in_data.first_denominator == '0) ||
                     (i_in_data.second_denominator == '0);
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod[31:0];
        end
        if (i_cmd.acc_ld) begin
            r_num <= r_prod;
        end else if (i_cmd.acc_add) begin
            r_num <= r_num + r_prod;
        end
        if (i_cmd.sum_ld) begin
            r_neg <= r_num[31];
            r_mag <= num_abs[C_DIV_W-1:0];
            r_a   <= num_abs[C_DIV_W-1:0];
            r_den <= r_prod[C_DIV_W-1:0];
            r_b   <= r_prod[C_DIV_W-1:0];
        end
        if (i_cmd.div_start) begin
            r_op <= i_cmd.div_op;
        end
        // Take divider result according to the operation in flight
        if (div_done) begin
            case (r_op)
                DIV_MOD: begin
                    r_a <= r_b;
                    r_b <= div_rem;
                end
                DIV_NUM: r_qnum <= div_quo;
                DIV_DEN: r_qden <= div_quo;
                default: r_qden <= div_quo;
            endcase
        end
    end

    // Form the result for the output register
    always_comb begin
        if (r_err) begin
            n_out.sum_numerator   = '0;
            n_out.sum_denominator = '0;
            n_out.status          = 1'b1;
        end else if (r_num == '0) begin
            n_out.sum_numerator   = '0;
            n_out.sum_denominator = 30'd1;
            n_out.status          = 1'b0;
        end else begin
            n_out.sum_numerator   = r_neg ? -$signed({1'b0, r_qnum})
                                          :  $signed({1'b0, r_qnum});
            n_out.sum_denominator = r_qden[29:0];
            n_out.status          = 1'b0;
        end
    end

    // Output register: hold until the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out <= n_out;
        end
    end

    assign o_sts.err      = r_err;
    assign o_sts.num_zero = (r_num == '0);
    assign o_sts.b_zero   = (r_b == '0);
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ sv/fadd_ctrl.sv @@
// Controller state machine: sequences multiply, Euclid loop and final reductions.
// Depends on fadd_pkg for the command and status structs.
module fadd_ctrl
    import fadd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MUL_A    = 4'd1;
    localparam logic [3:0] S_MUL_B    = 4'd2;
    localparam logic [3:0] S_MUL_C    = 4'd3;
    localparam logic [3:0] S_SUM      = 4'd4;
    localparam logic [3:0] S_CHK      = 4'd5;
    localparam logic [3:0] S_WAIT_MOD = 4'd6;
    localparam logic [3:0] S_WAIT_NUM = 4'd7;
    localparam logic [3:0] S_DEN      = 4'd8;
    localparam logic [3:0] S_WAIT_DEN = 4'd9;
    localparam logic [3:0] S_FINISH   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL_A;
                end
            end
            // One product per cycle through the shared multiplier
            S_MUL_A: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_N1D2;
                n_state       = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_N2D1;
                o_cmd.acc_ld  = 1'b1;
                n_state       = S_MUL_C;
            end
            S_MUL_C: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_D1D2;
                o_cmd.acc_add = 1'b1;
                n_state       = S_SUM;
            end
            // Skip the loop for error and zero sums
            S_SUM: begin
                o_cmd.sum_ld = 1'b1;
                if (i_sts.err || i_sts.num_zero) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_CHK;
                end
            end
            // Euclid: another remainder step, or divide by the gcd
            S_CHK: begin
                o_cmd.div_start = 1'b1;
                if (i_sts.b_zero) begin
                    o_cmd.div_op = DIV_NUM;
                    n_state      = S_WAIT_NUM;
                end else begin
                    o_cmd.div_op = DIV_MOD;
                    n_state      = S_WAIT_MOD;
                end
            end
            S_WAIT_MOD: begin
                if (i_sts.div_done) begin
                    n_state = S_CHK;
                end
            end
            S_WAIT_NUM: begin
                if (i_sts.div_done) begin
                    n_state = S_DEN;
                end
            end
            S_DEN: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_DEN;
                n_state         = S_WAIT_DEN;
            end
            S_WAIT_DEN: begin
                if (i_sts.div_done) begin
                    n_state = S_FINISH;
                end
            end
            // Hold until the output register can take the result
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/fraction_add_reduce.sv @@
// Top level: adds two fractions and reduces the sum by Euclid's gcd.
// Depends on fadd_pkg; instantiates fadd_ctrl and fadd_dp.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         i_in_valid / o_in_ready   i_in_data  (t_in)
//   output    out        o_out_valid / i_out_ready o_out_data (t_out)
//
// One transaction at a time. An error or zero sum skips every division. Otherwise each
// of the k Euclid remainder steps and both final divisions runs on the shared 31-step
// restoring divider.
// Reset (i_rst_n low, synchronous) clears the controller and output valid.
// A result waiting in the output register does not block the next input;
// a stalled output holds the controller at its final step.
module fraction_add_reduce
    import fadd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    fadd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fadd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ tb/fraction_add_reduce_tb.sv @@
// Self-checking testbench for fraction_add_reduce: directed and random fraction sums.
// Depends on fadd_pkg for the t_in and t_out types and on the fraction_add_reduce RTL.
module fraction_add_reduce_tb
    import fadd_pkg::*;
();

    localparam int C_HALF_PERIOD  = 5;
    localparam int C_RESET_CYCLES = 5;
    localparam int C_SETTLE_CYCLES = 2000;      // above the longest Euclid run
    localparam int C_TIMEOUT      = 200_000_000;
    localparam int C_RANDOM_ITEMS = 450;        // per idling phase

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    t_out expected_sums[$];
    int   error_count  = 0;
    int   in_idle_pct  = 0;
    int   out_idle_pct = 0;

    fraction_add_reduce u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #C_HALF_PERIOD i_clk = ~i_clk;

    // Add the two fractions, then reduce by the gcd of magnitude and denominator
    function automatic t_out predict_sum(input t_in f);
        longint n1, d1, n2, d2, num, den, mag, a, b, r;
        t_out   res;
        n1 = longint'($signed(f.first_numerator));
        d1 = longint'(f.first_denominator);
        n2 = longint'($signed(f.second_numerator));
        d2 = longint'(f.second_denominator);
        res = '0;
        if (d1 == 0 || d2 == 0) begin
            res.status = 1'b1;
        end else begin
            num = n1 * d2 + n2 * d1;
            den = d1 * d2;
            if (num == 0) begin
                res.sum_denominator = 30'd1;
            end else begin
                mag = (num < 0) ? -num : num;
                a = mag;
                b = den;
                while (b != 0) begin
                    r = a % b;
                    a = b;
                    b = r;
                end
                mag = mag / a;
                den = den / a;
                res.sum_numerator   = (num < 0) ? 32'(-mag) : 32'(mag);
                res.sum_denominator = 30'(den);
            end
        end
        return res;
    endfunction

    function automatic t_in make_fraction(input int n1, input int d1, input int n2,
                                          input int d2);
        t_in f;
        f.first_numerator    = 16'(n1);
        f.first_denominator  = 15'(d1);
        f.second_numerator   = 16'(n2);
        f.second_denominator = 15'(d2);
        return f;
    endfunction

    // Mostly well-formed sums; some zero sums, zero denominators and small operands
    function automatic t_in random_fraction();
        t_in         f;
        logic [31:0] rnd;
        int unsigned pick;
        int          n;
        int          d;
        rnd = $urandom;
        f.first_numerator  = rnd[15:0];
        f.second_numerator = rnd[31:16];
        rnd = $urandom;
        f.first_denominator  = rnd[14:0];
        f.second_denominator = rnd[30:16];
        pick = $urandom_range(99);
        if (pick < 5) begin
            case ($urandom_range(2))
                0: f.first_denominator = '0;
                1: f.second_denominator = '0;
                default: begin
                    f.first_denominator  = '0;
                    f.second_denominator = '0;
                end
            endcase
        end else if (pick < 15) begin
            d = $urandom_range(32767, 1);
            n = int'($signed(f.first_numerator));
            if (n == -32768)
                n = -32767;
            if (d <= 16383 && $urandom_range(1)) begin
                // n1/d + n2/(2d) cancels when n2 = -2*n1
                n = n / 2;
                f = make_fraction(n, d, -2 * n, 2 * d);
            end else begin
                f = make_fraction(n, d, -n, d);
            end
        end else if (pick < 35) begin
            f = make_fraction(int'($urandom_range(128)) - 64, $urandom_range(64, 1),
                              int'($urandom_range(128)) - 64, $urandom_range(64, 1));
        end
        return f;
    endfunction

    // Present one transaction, with random idle cycles ahead of it
    task automatic send_fraction(input t_in f);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        expected_sums.push_back(predict_sum(f));
    endtask

    // Hold the input idle until every pending result has been taken
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_extremes();
        send_fraction(make_fraction(32767, 32767, 32767, 32767));
        send_fraction(make_fraction(-32768, 32767, -32768, 32767));
        send_fraction(make_fraction(-32768, 1, -32768, 1));
        send_fraction(make_fraction(32767, 1, 32767, 1));
        send_fraction(make_fraction(-32768, 32767, -32768, 32765));
        send_fraction(make_fraction(32767, 32766, -32768, 32767));
        send_fraction(make_fraction(1, 32767, 1, 32766));
        send_fraction(make_fraction(1, 2, 1, 3));
        send_fraction(make_fraction(1, 2, 1, 2));
        send_fraction(make_fraction(-1, 2, -1, 2));
        send_fraction(make_fraction(3, 4, -1, 4));
        // Consecutive Fibonacci terms give a long Euclid run
        send_fraction(make_fraction(17711, 28657, 0, 1));
    endtask

    task automatic test_zero_denominator();
        send_fraction(make_fraction(1, 0, 1, 1));
        send_fraction(make_fraction(1, 1, 1, 0));
        send_fraction(make_fraction(0, 0, 0, 0));
        send_fraction(make_fraction(-32768, 0, 32767, 32767));
    endtask

    task automatic test_zero_sum();
        send_fraction(make_fraction(0, 1, 0, 1));
        send_fraction(make_fraction(0, 32767, 0, 5));
        send_fraction(make_fraction(5, 7, -5, 7));
        send_fraction(make_fraction(-32768, 2, 16384, 1));
        send_fraction(make_fraction(32767, 32767, -32767, 32767));
    endtask

    // Random sums; optionally drain the block halfway through
    task automatic test_random(input int in_pct, input int out_pct, input bit drain_midway);
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        for (int i = 0; i < C_RANDOM_ITEMS; i++) begin
            if (drain_midway && i == C_RANDOM_ITEMS / 2)
                wait_for_results();
            send_fraction(random_fraction());
        end
    endtask

    // Check each accepted result against the oldest expectation; randomize ready
    always @(posedge i_clk) begin : check_sums
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_sums.size() == 0) begin
                $error("result with no pending transaction: %h", o_out_data);
                error_count++;
            end else begin
                want = expected_sums.pop_front();
                if (o_out_data.sum_numerator !== want.sum_numerator) begin
                    $error("sum_numerator: expected %0d, got %0d",
                           want.sum_numerator, o_out_data.sum_numerator);
                    error_count++;
                end
                if (o_out_data.sum_denominator !== want.sum_denominator) begin
                    $error("sum_denominator: expected %0d, got %0d",
                           want.sum_denominator, o_out_data.sum_denominator);
                    error_count++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    error_count++;
                end
            end
        end
        i_out_ready <= i_rst_n && ($urandom_range(99) >= out_idle_pct);
    end

    initial begin
        repeat (C_RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_idle_pct  = 7;
        out_idle_pct = 85;
        test_extremes();
        test_zero_denominator();
        test_zero_sum();

        test_random(7, 85, 1'b1);
        test_random(85, 7, 1'b0);
        test_random(0, 0, 1'b0);

        // Drain, then give any stray output time to show up
        wait_for_results();
        repeat (C_SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_sums.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog against a hung handshake
    initial begin
        #(C_TIMEOUT);
        $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
sv/fadd_pkg.sv
sv/fadd_div.sv
sv/fadd_dp.sv
sv/fadd_ctrl.sv
sv/fraction_add_reduce.sv
tb/fraction_add_reduce_tb.sv
